@@ hw/rtl/dsmq_pkg.sv @@
// Shared types and constants of the deadline-sorted message queue.
`default_nettype none

package dsmq_pkg;

  localparam int unsigned HANDLE_W = 8;
  localparam int unsigned NAME_W   = 16;
  localparam int unsigned TIME_W   = 48;
  localparam int unsigned POLL_W   = 16;
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned STATUS_W = 3;

  localparam int unsigned IN_DATA_W  = 120;
  localparam int unsigned OUT_DATA_W = 80;

  localparam logic [POLL_W-1:0] POLL_RESET = 16'd30000;

  // Operation carried with each input item.
  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_POP    = 2'd2,
    ACT_STOP   = 2'd3
  } action_e;

  // Outcome reported with each result item.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_QUIT    = 3'd1,
    ST_FULL    = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_NOT_DUE = 3'd4
  } status_e;

  // One stored queue entry.
  typedef struct packed {
    logic [TIME_W-1:0]   due;
    logic [NAME_W-1:0]   name;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  // Result of the shared subtract and compare unit.
  typedef struct packed {
    logic [TIME_W-1:0] diff;
    logic              borrow;
    logic              zero;
  } sub_res_t;

endpackage

`default_nettype wire

@@ hw/rtl/dsmq_sub.sv @@
// Shared 48-bit subtract and compare unit of the queue sequencer.
`default_nettype none

module dsmq_sub
  import dsmq_pkg::*;
(
  input  logic [TIME_W-1:0] a_i,
  input  logic [TIME_W-1:0] b_i,
  output sub_res_t          res_o
);

  logic [TIME_W:0] full_diff;

  // One extra bit catches the borrow out of the top.
  assign full_diff    = {1'b0, a_i} - {1'b0, b_i};
  assign res_o.diff   = full_diff[TIME_W-1:0];
  assign res_o.borrow = full_diff[TIME_W];
  assign res_o.zero   = (full_diff[TIME_W-1:0] == '0);

endmodule

`default_nettype wire

@@ hw/rtl/dsmq_ram.sv @@
// Entry store of the queue: one write port and one registered read port.
`default_nettype none

module dsmq_ram
  import dsmq_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem [DEPTH];
  entry_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hw/rtl/deadline_sorted_message_queue.sv @@
// Top level of the deadline-sorted message queue: sequencer, flags and stream ports.
//
// Commands arrive on the s_axis channel, one transfer per command: tuser holds the
// action (insert, delete by name, pop if due, stop), tdata the handle, name, due
// time and current time. Each command returns exactly one transfer on m_axis with
// the status in tuser and the popped handle, name, wait time and wake flag in tdata.
// The idle poll interval is written through the cfg channel, which is always ready.
//
// Commands are worked one at a time; s_axis_tready is low while one is in progress.
// Entries sit in a memory with one read and one write port, and the sequencer walks
// them one entry per cycle, using a single 48-bit subtract and compare unit.
// Insert walks the entries that move; delete visits every stored entry; pop checks
// the head and, when it is taken, shifts the remaining entries down. Stop and
// commands rejected at once go straight to the finish state, which loads the output
// register: m_axis_tvalid and s_axis_tready rise together right after it.
//
// Reset empties the queue, clears the blocked and quit flags and sets the poll
// interval to 30000. While m_axis is stalled the result holds, the next command is
// still accepted, and its result waits in the sequencer until the output frees up.
`default_nettype none

module deadline_sorted_message_queue
  import dsmq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [POLL_W-1:0]     cfg_data_i,     // idle_poll_ms

  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // msg_handle [7:0], msg_name [23:8], due_ms [71:24], now_ms [119:72]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic [ACTION_W-1:0]   s_axis_tuser,   // action [1:0]

  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // out_handle [7:0], out_name [23:8], wait_ms [71:24], wake [72], zero [79:73]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic [STATUS_W-1:0]   m_axis_tuser    // status [2:0]
);

  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_WALK,
    S_INS_HEAD,
    S_DEL_WALK,
    S_POP_CHK,
    S_POP_SHIFT,
    S_FINISH
  } state_e;

  typedef struct packed {
    status_e             status;
    logic [HANDLE_W-1:0] handle;
    logic [NAME_W-1:0]   name;
    logic [TIME_W-1:0]   wait_ms;
    logic                wake;
  } result_t;

  state_e              state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic [IW-1:0]       ptr_q, ptr_d;
  logic [CW-1:0]       wr_q, wr_d;
  logic                blocked_q, blocked_d;
  logic                quit_q, quit_d;
  logic [POLL_W-1:0]   poll_q;
  entry_t              item_q, item_d;
  logic [TIME_W-1:0]   now_q, now_d;
  result_t             res_q, res_d;
  result_t             out_q, out_d;
  logic                out_valid_q, out_valid_d;

  logic                in_xfer;
  entry_t              in_entry;
  action_e             in_action;
  logic [CW-1:0]       cnt_m1;
  logic [IW-1:0]       last_idx;
  logic [IW-1:0]       ptr_p1;
  logic [IW-1:0]       ptr_m1;

  logic                mem_we;
  logic [IW-1:0]       mem_waddr;
  entry_t              mem_wdata;
  logic [IW-1:0]       mem_raddr;
  entry_t              mem_rdata;

  logic [TIME_W-1:0]   sub_a, sub_b;
  sub_res_t            sub_res;

  // Input unpacking.
  assign in_xfer         = s_axis_tvalid && s_axis_tready;
  assign in_action       = action_e'(s_axis_tuser);
  assign in_entry.handle = s_axis_tdata[7:0];
  assign in_entry.name   = s_axis_tdata[23:8];
  assign in_entry.due    = s_axis_tdata[71:24];

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;

  // Index helpers.
  assign cnt_m1   = count_q - CW'(1);
  assign last_idx = cnt_m1[IW-1:0];
  assign ptr_p1   = ptr_q + IW'(1);
  assign ptr_m1   = ptr_q - IW'(1);

  // Entry store.
  dsmq_ram #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (IW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Shared subtractor: due minus now for pops, new due minus stored due for inserts.
  always_comb begin
    if (state_q == S_POP_CHK) begin
      sub_a = mem_rdata.due;
      sub_b = now_q;
    end else begin
      sub_a = item_q.due;
      sub_b = mem_rdata.due;
    end
  end

  dsmq_sub u_sub (
    .a_i   (sub_a),
    .b_i   (sub_b),
    .res_o (sub_res)
  );

  // Sequencer next-state logic.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    wr_d        = wr_q;
    blocked_d   = blocked_q;
    quit_d      = quit_q;
    item_d      = item_q;
    now_d       = now_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = item_q;
    mem_raddr   = '0;

    // Output register drains on a transfer.
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          item_d = in_entry;
          now_d  = s_axis_tdata[119:72];
          res_d  = '0;
          case (in_action)
            ACT_INSERT: begin
              if (quit_q) begin
                res_d.status = ST_QUIT;
                state_d      = S_FINISH;
              end else if (count_q == CW'(QUEUE_DEPTH)) begin
                res_d.status = ST_FULL;
                state_d      = S_FINISH;
              end else if (count_q == '0) begin
                state_d = S_INS_HEAD;
              end else begin
                // Walk from the tail toward the head.
                mem_raddr = last_idx;
                ptr_d     = last_idx;
                state_d   = S_INS_WALK;
              end
            end
            ACT_DELETE: begin
              if (count_q == '0) begin
                state_d = S_FINISH;
              end else begin
                mem_raddr = '0;
                ptr_d     = '0;
                wr_d      = '0;
                state_d   = S_DEL_WALK;
              end
            end
            ACT_POP: begin
              if (quit_q) begin
                res_d.status = ST_QUIT;
                state_d      = S_FINISH;
              end else if (count_q == '0) begin
                res_d.status  = ST_EMPTY;
                res_d.wait_ms = TIME_W'(poll_q);
                blocked_d     = 1'b1;
                state_d       = S_FINISH;
              end else begin
                mem_raddr = '0;
                state_d   = S_POP_CHK;
              end
            end
            ACT_STOP: begin
              quit_d  = 1'b1;
              state_d = S_FINISH;
            end
            default: begin
              state_d = S_FINISH;
            end
          endcase
        end
      end

      // Move one entry up per cycle until one due no later than the new one.
      S_INS_WALK: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_p1;
        if ((item_q.due != '0) && !sub_res.borrow) begin
          mem_wdata = item_q;
          count_d   = count_q + CW'(1);
          state_d   = S_FINISH;
        end else begin
          mem_wdata = mem_rdata;
          if (ptr_q == '0) begin
            state_d = S_INS_HEAD;
          end else begin
            mem_raddr = ptr_m1;
            ptr_d     = ptr_m1;
          end
        end
      end

      // New entry goes to the head; a waiting pop is released.
      S_INS_HEAD: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = item_q;
        count_d   = count_q + CW'(1);
        if (blocked_q) begin
          res_d.wake = 1'b1;
          blocked_d  = 1'b0;
        end
        state_d = S_FINISH;
      end

      // Compact the store, dropping every entry with the given name.
      S_DEL_WALK: begin
        mem_wdata = mem_rdata;
        mem_waddr = wr_q[IW-1:0];
        if (mem_rdata.name != item_q.name) begin
          mem_we = 1'b1;
          wr_d   = wr_q + CW'(1);
        end
        if (ptr_q == last_idx) begin
          count_d = wr_d;
          state_d = S_FINISH;
        end else begin
          mem_raddr = ptr_p1;
          ptr_d     = ptr_p1;
        end
      end

      // Head is in the read register: hand it out or report the wait.
      S_POP_CHK: begin
        if (!sub_res.borrow && !sub_res.zero) begin
          res_d.status  = ST_NOT_DUE;
          res_d.wait_ms = sub_res.diff;
          blocked_d     = 1'b1;
          state_d       = S_FINISH;
        end else begin
          res_d.handle = mem_rdata.handle;
          res_d.name   = mem_rdata.name;
          blocked_d    = 1'b0;
          if (count_q == CW'(1)) begin
            count_d = '0;
            state_d = S_FINISH;
          end else begin
            mem_raddr = IW'(1);
            ptr_d     = IW'(1);
            state_d   = S_POP_SHIFT;
          end
        end
      end

      // Move the remaining entries down by one.
      S_POP_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_m1;
        mem_wdata = mem_rdata;
        if (ptr_q == last_idx) begin
          count_d = cnt_m1;
          state_d = S_FINISH;
        end else begin
          mem_raddr = ptr_p1;
          ptr_d     = ptr_p1;
        end
      end

      // Hand the result to the output register once it is free.
      S_FINISH: begin
        if (!out_valid_q || m_axis_tready) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State, flags, configuration and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      ptr_q       <= '0;
      wr_q        <= '0;
      blocked_q   <= 1'b0;
      quit_q      <= 1'b0;
      poll_q      <= POLL_RESET;
      item_q      <= '0;
      now_q       <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      wr_q        <= wr_d;
      blocked_q   <= blocked_d;
      quit_q      <= quit_d;
      item_q      <= item_d;
      now_q       <= now_d;
      res_q       <= res_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        poll_q <= cfg_data_i;
      end
    end
  end

  // Output packing.
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {7'b0, out_q.wake, out_q.wait_ms, out_q.name, out_q.handle};

  // The fill count never passes the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("queue count exceeds capacity");

  // Once stopped, the queue stays stopped until reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(quit_q))
    else $error("quit flag cleared without reset");

  // A finished result waits while the output register is held by a stalled transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && out_valid_q && !m_axis_tready) |=> (state_q == S_FINISH))
    else $error("result overwrote a pending output");

  // Wake is only reported with a successful insert.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.wake) |-> (out_q.status == ST_OK && out_q.wait_ms == '0))
    else $error("wake reported with a failing result");

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// Self-checking testbench for the deadline-sorted message queue.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dsmq_pkg::*;

  localparam int unsigned QDEPTH       = 16;
  localparam int unsigned PLAN_ROWS    = 29;
  localparam int unsigned TAIL_START   = 24;
  localparam int unsigned PHASE_ITEMS  = 170;
  localparam int unsigned HOLD_CYCLES  = 64;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned STALL_LIMIT  = 2000;

  localparam logic [TIME_W-1:0] MAX_MS    = '1;
  localparam logic [NAME_W-1:0] NAME_X    = 16'h0A0A;
  localparam logic [NAME_W-1:0] NAME_Y    = 16'h5050;
  localparam logic [NAME_W-1:0] NAME_NONE = 16'h7777;

  // One command as it travels on the input stream.
  typedef struct packed {
    action_e             action;
    logic [HANDLE_W-1:0] handle;
    logic [NAME_W-1:0]   name;
    logic [TIME_W-1:0]   due_ms;
    logic [TIME_W-1:0]   now_ms;
  } cmd_t;

  // One reply as it travels on the output stream.
  typedef struct packed {
    status_e             status;
    logic [HANDLE_W-1:0] handle;
    logic [NAME_W-1:0]   name;
    logic [TIME_W-1:0]   wait_ms;
    logic                wake;
  } reply_t;

  // Directed row: a command and, where obvious, its reply typed in by hand.
  typedef struct packed {
    cmd_t   c;
    logic   known;
    reply_t r;
  } plan_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [POLL_W-1:0]     cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [ACTION_W-1:0]   s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]   m_axis_tuser;

  // Shadow copy of the queue contents, flags and poll interval.
  logic [TIME_W-1:0]   shadow_due    [QDEPTH];
  logic [NAME_W-1:0]   shadow_name   [QDEPTH];
  logic [HANDLE_W-1:0] shadow_handle [QDEPTH];
  int unsigned         shadow_count;
  logic                shadow_blocked;
  logic                shadow_quit;
  logic [POLL_W-1:0]   shadow_poll;

  reply_t      pending_replies[$];
  plan_row_t   plan [PLAN_ROWS];
  logic [TIME_W-1:0] clock_ms;
  logic        steady_run;
  logic        hold_off_req;
  int unsigned mismatches;
  int unsigned cmds_sent;
  int unsigned replies_seen;
  int unsigned wakes_seen;
  int unsigned status_hits [5];
  int unsigned quiet_cycles;

  deadline_sorted_message_queue #(
    .QUEUE_DEPTH(QDEPTH)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Free-running clock, 8 ns period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic cmd_t mk_cmd(action_e a, logic [HANDLE_W-1:0] h, logic [NAME_W-1:0] n,
                                  logic [TIME_W-1:0] d, logic [TIME_W-1:0] t);
    cmd_t c;
    c.action = a;
    c.handle = h;
    c.name   = n;
    c.due_ms = d;
    c.now_ms = t;
    return c;
  endfunction

  function automatic reply_t typed_reply(status_e st, logic [TIME_W-1:0] w, logic wk);
    reply_t r;
    r = '0;
    r.status  = st;
    r.wait_ms = w;
    r.wake    = wk;
    return r;
  endfunction

  function automatic logic [TIME_W-1:0] rand_ms();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    return v[TIME_W-1:0];
  endfunction

  // Applies one command to the shadow queue and returns the reply it must give.
  function automatic reply_t queue_step(cmd_t c);
    reply_t      r;
    int unsigned pos;
    int unsigned i;
    int unsigned wr;
    r = typed_reply(ST_OK, '0, 1'b0);
    case (c.action)
      ACT_INSERT: begin
        if (shadow_quit) begin
          r.status = ST_QUIT;
        end else if (shadow_count >= QDEPTH) begin
          r.status = ST_FULL;
        end else begin
          // Ties go behind existing entries; a zero due time goes to the head.
          pos = 0;
          if (c.due_ms != '0) begin
            while (pos < shadow_count && shadow_due[pos] <= c.due_ms) pos++;
          end
          for (i = shadow_count; i > pos; i--) begin
            shadow_due[i]    = shadow_due[i-1];
            shadow_name[i]   = shadow_name[i-1];
            shadow_handle[i] = shadow_handle[i-1];
          end
          shadow_due[pos]    = c.due_ms;
          shadow_name[pos]   = c.name;
          shadow_handle[pos] = c.handle;
          shadow_count++;
          if (pos == 0 && shadow_blocked) begin
            r.wake = 1'b1;
            shadow_blocked = 1'b0;
          end
        end
      end
      ACT_DELETE: begin
        // Compact the survivors in place, so back-to-back matches all go.
        wr = 0;
        for (i = 0; i < shadow_count; i++) begin
          if (shadow_name[i] != c.name) begin
            shadow_due[wr]    = shadow_due[i];
            shadow_name[wr]   = shadow_name[i];
            shadow_handle[wr] = shadow_handle[i];
            wr++;
          end
        end
        shadow_count = wr;
      end
      ACT_POP: begin
        if (shadow_quit) begin
          r.status = ST_QUIT;
        end else if (shadow_count == 0) begin
          shadow_blocked = 1'b1;
          r.status  = ST_EMPTY;
          r.wait_ms = TIME_W'(shadow_poll);
        end else if (c.now_ms < shadow_due[0]) begin
          shadow_blocked = 1'b1;
          r.status  = ST_NOT_DUE;
          r.wait_ms = shadow_due[0] - c.now_ms;
        end else begin
          r.handle = shadow_handle[0];
          r.name   = shadow_name[0];
          for (i = 1; i < shadow_count; i++) begin
            shadow_due[i-1]    = shadow_due[i];
            shadow_name[i-1]   = shadow_name[i];
            shadow_handle[i-1] = shadow_handle[i];
          end
          shadow_count--;
          shadow_blocked = 1'b0;
        end
      end
      default: begin
        shadow_quit = 1'b1;
      end
    endcase
    return r;
  endfunction

  // Random command: mostly due times near a slowly advancing clock, a few extremes.
  function automatic cmd_t random_cmd(int unsigned ins_pct, int unsigned pop_pct);
    int unsigned roll;
    action_e     a;
    logic [NAME_W-1:0] n;
    logic [TIME_W-1:0] d;
    logic [TIME_W-1:0] t;
    clock_ms = clock_ms + TIME_W'($urandom_range(40));
    roll = $urandom_range(99);
    if (roll < ins_pct) a = ACT_INSERT;
    else if (roll < ins_pct + pop_pct) a = ACT_POP;
    else a = ACT_DELETE;
    // A small pool of names makes deletes hit several entries at once.
    if ($urandom_range(99) < 80) n = 16'hA5A0 | NAME_W'($urandom_range(3));
    else n = NAME_W'($urandom());
    roll = $urandom_range(99);
    if (roll < 5) d = '0;
    else if (roll < 8) d = MAX_MS;
    else if (roll < 14) d = rand_ms();
    else d = clock_ms + TIME_W'($urandom_range(300));
    roll = $urandom_range(99);
    if (roll < 5) t = rand_ms();
    else if (roll < 7) t = MAX_MS;
    else t = clock_ms;
    return mk_cmd(a, HANDLE_W'($urandom()), n, d, t);
  endfunction

  // Offers one command, waits for its transfer and records the reply it must give.
  task automatic issue(input cmd_t c, input logic known, input reply_t typed);
    reply_t r;
    while (!steady_run && $urandom_range(99) < 25) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {c.now_ms, c.due_ms, c.name, c.handle};
    s_axis_tuser  <= c.action;
    do @(posedge clk_i); while (!s_axis_tready);
    r = queue_step(c);
    pending_replies.push_back(known ? typed : r);
    cmds_sent++;
  endtask

  // Lets the queue go quiet, then writes a new idle poll interval.
  task automatic set_poll(input logic [POLL_W-1:0] v);
    s_axis_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    shadow_poll = v;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic check_field(input string label, input logic [TIME_W-1:0] want,
                             input logic [TIME_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
    end
  endtask

  // Sink side: random back-pressure, plus one long hold-off on request.
  initial begin : sink
    int unsigned k;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        for (k = 0; k < HOLD_CYCLES; k++) @(posedge clk_i);
        hold_off_req = 1'b0;
      end
      m_axis_tready <= steady_run || ($urandom_range(99) >= 25);
    end
  end

  // Every reply transfer is compared with the oldest outstanding expectation.
  always @(posedge clk_i) begin : scoreboard
    reply_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      replies_seen++;
      if (m_axis_tuser < 5) status_hits[m_axis_tuser]++;
      if (m_axis_tdata[72]) wakes_seen++;
      if (pending_replies.size() == 0) begin
        mismatches++;
        $display("%0t ns: reply with none expected, actual status %0d data %0h",
                 $time, m_axis_tuser, m_axis_tdata);
      end else begin
        want = pending_replies.pop_front();
        check_field("status", TIME_W'(want.status), TIME_W'(m_axis_tuser));
        check_field("out_handle", TIME_W'(want.handle), TIME_W'(m_axis_tdata[7:0]));
        check_field("out_name", TIME_W'(want.name), TIME_W'(m_axis_tdata[23:8]));
        check_field("wait_ms", want.wait_ms, m_axis_tdata[71:24]);
        check_field("wake", TIME_W'(want.wake), TIME_W'(m_axis_tdata[72]));
      end
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk_i) begin : watchdog
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles, %0d replies outstanding",
               $time, STALL_LIMIT, pending_replies.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned k;
    int unsigned ph;
    int unsigned ins_pct;
    int unsigned pop_pct;
    logic [POLL_W-1:0] poll_val;

    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ACT_INSERT;
    steady_run    = 1'b0;
    hold_off_req  = 1'b0;
    mismatches    = 0;
    cmds_sent     = 0;
    replies_seen  = 0;
    wakes_seen    = 0;
    quiet_cycles  = 0;
    clock_ms      = TIME_W'(1000);
    status_hits   = '{default: 0};
    shadow_count   = 0;
    shadow_blocked = 1'b0;
    shadow_quit    = 1'b0;
    shadow_poll    = POLL_RESET;

    // Directed rows: empty pop, wake on head insert, extremes, fill to full, deletes.
    plan[0]  = '{mk_cmd(ACT_POP, 8'h00, 16'h0000, '0, '0), 1'b1,
                 typed_reply(ST_EMPTY, TIME_W'(30000), 1'b0)};
    plan[1]  = '{mk_cmd(ACT_INSERT, 8'hFF, 16'hFFFF, MAX_MS, '0), 1'b1,
                 typed_reply(ST_OK, '0, 1'b1)};
    plan[2]  = '{mk_cmd(ACT_POP, 8'h00, 16'h0000, '0, '0), 1'b0, '0};
    plan[3]  = '{mk_cmd(ACT_INSERT, 8'h00, 16'h0000, '0, '0), 1'b1,
                 typed_reply(ST_OK, '0, 1'b1)};
    plan[4]  = '{mk_cmd(ACT_POP, 8'h00, 16'h0000, '0, '0), 1'b0, '0};
    plan[5]  = '{mk_cmd(ACT_INSERT, 8'h01, NAME_X, 48'd100, '0), 1'b0, '0};
    plan[6]  = '{mk_cmd(ACT_INSERT, 8'h02, NAME_X, 48'd100, '0), 1'b0, '0};
    plan[7]  = '{mk_cmd(ACT_INSERT, 8'h03, NAME_Y, 48'd50, '0), 1'b0, '0};
    plan[8]  = '{mk_cmd(ACT_INSERT, 8'h04, NAME_X, 48'd0, '0), 1'b0, '0};
    plan[9]  = '{mk_cmd(ACT_INSERT, 8'h05, NAME_Y, 48'd200, '0), 1'b0, '0};
    plan[10] = '{mk_cmd(ACT_INSERT, 8'h06, NAME_X, 48'd100, '0), 1'b0, '0};
    plan[11] = '{mk_cmd(ACT_INSERT, 8'h07, NAME_X, 48'd75, '0), 1'b0, '0};
    plan[12] = '{mk_cmd(ACT_INSERT, 8'h08, NAME_Y, 48'd0, '0), 1'b0, '0};
    plan[13] = '{mk_cmd(ACT_INSERT, 8'h09, NAME_Y, 48'd300, '0), 1'b0, '0};
    plan[14] = '{mk_cmd(ACT_INSERT, 8'h0A, NAME_X, 48'd100, '0), 1'b0, '0};
    plan[15] = '{mk_cmd(ACT_INSERT, 8'h0B, NAME_Y, 48'd50, '0), 1'b0, '0};
    plan[16] = '{mk_cmd(ACT_INSERT, 8'h0C, NAME_X, 48'd1, '0), 1'b0, '0};
    plan[17] = '{mk_cmd(ACT_INSERT, 8'h0D, NAME_X, 48'd200, '0), 1'b0, '0};
    plan[18] = '{mk_cmd(ACT_INSERT, 8'h0E, NAME_Y, 48'd999, '0), 1'b0, '0};
    plan[19] = '{mk_cmd(ACT_INSERT, 8'h0F, NAME_X, 48'd150, '0), 1'b0, '0};
    plan[20] = '{mk_cmd(ACT_INSERT, 8'h10, NAME_Y, 48'd10, '0), 1'b1,
                 typed_reply(ST_FULL, '0, 1'b0)};
    plan[21] = '{mk_cmd(ACT_POP, 8'h00, 16'h0000, '0, MAX_MS), 1'b0, '0};
    plan[22] = '{mk_cmd(ACT_DELETE, 8'h00, NAME_X, '0, '0), 1'b1,
                 typed_reply(ST_OK, '0, 1'b0)};
    plan[23] = '{mk_cmd(ACT_DELETE, 8'h00, NAME_NONE, '0, '0), 1'b1,
                 typed_reply(ST_OK, '0, 1'b0)};
    // Closing rows: stop, everything after it, and a repeated stop.
    plan[24] = '{mk_cmd(ACT_STOP, 8'h00, 16'h0000, '0, '0), 1'b1,
                 typed_reply(ST_OK, '0, 1'b0)};
    plan[25] = '{mk_cmd(ACT_INSERT, 8'h42, NAME_Y, 48'd5, '0), 1'b1,
                 typed_reply(ST_QUIT, '0, 1'b0)};
    plan[26] = '{mk_cmd(ACT_POP, 8'h00, 16'h0000, '0, MAX_MS), 1'b1,
                 typed_reply(ST_QUIT, '0, 1'b0)};
    plan[27] = '{mk_cmd(ACT_DELETE, 8'h00, NAME_Y, '0, '0), 1'b1,
                 typed_reply(ST_OK, '0, 1'b0)};
    plan[28] = '{mk_cmd(ACT_STOP, 8'h00, 16'h0000, '0, '0), 1'b1,
                 typed_reply(ST_OK, '0, 1'b0)};

    // Reset is asserted at the start and released once.
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (k = 0; k < TAIL_START; k++) issue(plan[k].c, plan[k].known, plan[k].r);

    // Random phases, each under a new poll interval, with the operation mix changed in phases 1 and 2.
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: poll_val = 16'hFFFF;
        1: poll_val = 16'h0001;
        2: poll_val = 16'h0000;
        default: poll_val = POLL_W'($urandom_range(65535, 1));
      endcase
      set_poll(poll_val);
      ins_pct    = (ph == 1) ? 60 : (ph == 2) ? 30 : 45;
      pop_pct    = (ph == 1) ? 25 : (ph == 2) ? 55 : 40;
      steady_run = (ph == 1);
      // The long sink hold-off starts at the head of phase 2.
      if (ph == 2) hold_off_req = 1'b1;
      for (k = 0; k < PHASE_ITEMS; k++) issue(random_cmd(ins_pct, pop_pct), 1'b0, '0);
    end
    steady_run = 1'b0;

    for (k = TAIL_START; k < PLAN_ROWS; k++) issue(plan[k].c, plan[k].known, plan[k].r);
    s_axis_tvalid <= 1'b0;

    // Drain, then give the block time to show any stray reply.
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d commands, checked %0d replies, %0d wakes.",
             cmds_sent, replies_seen, wakes_seen);
    $display("Status mix: ok %0d, quit %0d, full %0d, empty %0d, not due %0d.",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3],
             status_hits[4]);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
